// ===== rtl/cac_pkg.sv =====
// ----------------------------------------------------------------------------
// cac_pkg
// Shared types and fixed widths of the component attribute accumulator.
// ----------------------------------------------------------------------------
package cac_pkg;

  // Fixed field and record widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned ENTRY_W   = 10;
  localparam int unsigned VOXEL_W   = 10;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned COUNT_W   = 31;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned HALF_W    = 20;
  localparam int unsigned R2_W      = 52;
  localparam int unsigned SQ_W      = 82;
  localparam int unsigned TERM_W    = 64;
  localparam int unsigned OUT_W     = 62;
  localparam int unsigned DIV_STEPS = 4;

  // Inertia correction term divides the count by this constant
  localparam logic [COUNT_W-1:0] INERTIA_DIVISOR = 31'd6;

  typedef enum logic [OP_W-1:0] {
    OP_NEW   = 2'd0,
    OP_ADD   = 2'd1,
    OP_MERGE = 2'd2,
    OP_CLONE = 2'd3
  } cac_op_e;

  typedef enum logic [SEL_W-1:0] {
    SEL_AREA     = 3'd0,
    SEL_VOLUME   = 3'd1,
    SEL_DIAGONAL = 3'd2,
    SEL_INERTIA  = 3'd3,
    SEL_MEAN_X   = 3'd4,
    SEL_MEAN_Y   = 3'd5,
    SEL_MEAN_Z   = 3'd6
  } cac_sel_e;

  // Command class handed from the front to the back
  typedef struct packed {
    cac_op_e op;
    logic    reads_target;
    logic    reads_source;
  } cac_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ_TGT,
    B_READ_SRC,
    B_UPDATE,
    B_ATTR,
    B_WAIT
  } cac_bst_e;

  typedef enum logic [3:0] {
    A_IDLE,
    A_GEO_PROD,
    A_GEO_SUM,
    A_SQ_MUL,
    A_SQ_LAST,
    A_DIV_SQ,
    A_DIV_SIXTH,
    A_INERTIA,
    A_DIV_MEAN,
    A_DONE
  } cac_ast_e;

endpackage

// ===== rtl/component_attribute_accumulator.sv =====
// ----------------------------------------------------------------------------
// component_attribute_accumulator
// Per-component voxel record table with attribute report after each command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a two-entry queue
// sits in front of the table, so busy rises only when two commands wait. Each
// command produces one result, shown for a single cycle with result_valid_o;
// the receiver cannot stall it. A command first does the table
// read-modify-write (the pop, one registered read per record, so a new reads
// none, an add or a clone once and a merge twice, then the write), then the
// attribute. Mean and inertia wait on the shared divider, which retires four
// quotient bits per cycle, and inertia also on the nine partial products for
// the squared sums.
// ----------------------------------------------------------------------------
module component_attribute_accumulator #(
  parameter int unsigned ENTRY_COUNT   = 1024,
  parameter int unsigned COORD_BITS    = 10,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cac_pkg::SEL_W-1:0]    cfg_attribute_select_i,
  input  logic                         start,
  output logic                         busy,
  input  logic [cac_pkg::OP_W-1:0]     opcode_i,
  input  logic [cac_pkg::ENTRY_W-1:0]  target_entry_i,
  input  logic [cac_pkg::ENTRY_W-1:0]  source_entry_i,
  input  logic [cac_pkg::VOXEL_W-1:0]  voxel_x_i,
  input  logic [cac_pkg::VOXEL_W-1:0]  voxel_y_i,
  input  logic [cac_pkg::VOXEL_W-1:0]  voxel_z_i,
  output logic                         result_valid_o,
  output logic [cac_pkg::OUT_W-1:0]    attribute_value_o
);

  localparam int unsigned IDX_W = $clog2(ENTRY_COUNT);

  logic [cac_pkg::SEL_W-1:0] sel_q;
  logic                      cmd_valid, cmd_pop;
  cac_pkg::cac_ctl_t         cmd_ctl;
  logic [IDX_W-1:0]          cmd_target, cmd_source;
  logic [3*COORD_BITS-1:0]   cmd_voxel;
  logic [2*COORD_BITS+1:0]   cmd_r2;

  // Attribute select register, one beat per write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= cac_pkg::SEL_AREA;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sel_q <= cfg_attribute_select_i;
    end
  end

  cac_front #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .target_entry_i (target_entry_i),
    .source_entry_i (source_entry_i),
    .voxel_x_i      (voxel_x_i),
    .voxel_y_i      (voxel_y_i),
    .voxel_z_i      (voxel_z_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ctl_o      (cmd_ctl),
    .cmd_target_o   (cmd_target),
    .cmd_source_o   (cmd_source),
    .cmd_voxel_o    (cmd_voxel),
    .cmd_r2_o       (cmd_r2),
    .cmd_pop_i      (cmd_pop)
  );

  cac_back #(
    .ENTRY_COUNT   (ENTRY_COUNT),
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ctl_i      (cmd_ctl),
    .cmd_target_i   (cmd_target),
    .cmd_source_i   (cmd_source),
    .cmd_voxel_i    (cmd_voxel),
    .cmd_r2_i       (cmd_r2),
    .cmd_pop_o      (cmd_pop),
    .sel_i          (sel_q),
    .result_valid_o (result_valid_o),
    .result_value_o (attribute_value_o)
  );

endmodule

// ===== rtl/cac_ram.sv =====
// ----------------------------------------------------------------------------
// cac_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cac_div.sv =====
// ----------------------------------------------------------------------------
// cac_div
// Iterative unsigned divider, cac_pkg::DIV_STEPS restoring steps per clock cycle.
// ----------------------------------------------------------------------------
module cac_div #(
  parameter int unsigned DVD_W = 90,
  parameter int unsigned DSR_W = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEPS  = cac_pkg::DIV_STEPS;
  localparam int unsigned ROUNDS = (DVD_W + STEPS - 1) / STEPS;
  localparam int unsigned PAD_W  = ROUNDS * STEPS;
  localparam int unsigned CNT_W  = $clog2(ROUNDS + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PAD_W-1:0] quo_q, quo_n;
  logic [DSR_W-1:0] rem_q, rem_n;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W:0]   trial;

  // Shift in one dividend bit per step, subtract when it fits
  always_comb begin
    rem_n = rem_q;
    quo_n = quo_q;
    trial = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_n, quo_n[PAD_W-1]};
      quo_n = {quo_n[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        trial    = trial - {1'b0, dsr_q};
        quo_n[0] = 1'b1;
      end
      rem_n = trial[DSR_W-1:0];
    end
  end

  // Control: count rounds, flag completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROUNDS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then iterate
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= PAD_W'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_n;
      rem_q <= rem_n;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DVD_W-1:0];

endmodule

// ===== rtl/cac_attr.sv =====
// ----------------------------------------------------------------------------
// cac_attr
// Attribute unit: derives the selected attribute from one record.
// ----------------------------------------------------------------------------
module cac_attr #(
  parameter int unsigned COORD_BITS    = 10,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cac_pkg::SEL_W-1:0]    sel_i,
  input  logic [cac_pkg::COUNT_W-1:0]  count_i,
  input  logic [3*COORD_BITS-1:0]      box_min_i,
  input  logic [3*COORD_BITS-1:0]      box_max_i,
  input  logic [cac_pkg::SUM_W-1:0]    sum_x_i,
  input  logic [cac_pkg::SUM_W-1:0]    sum_y_i,
  input  logic [cac_pkg::SUM_W-1:0]    sum_z_i,
  input  logic [cac_pkg::R2_W-1:0]     r2_i,
  output logic                         done_o,
  output logic [cac_pkg::OUT_W-1:0]    value_o
);

  localparam int unsigned EXT_W  = COORD_BITS + 1;
  localparam int unsigned PAIR_W = 2 * EXT_W;
  localparam int unsigned VOL_W  = 3 * EXT_W;
  localparam int unsigned DIAG_W = PAIR_W + 2;
  localparam int unsigned DVD_W  = cac_pkg::SQ_W + FRACTION_BITS;
  localparam int unsigned HALF_W = cac_pkg::HALF_W;
  localparam int unsigned SQ_W   = cac_pkg::SQ_W;
  localparam int unsigned TERM_W = cac_pkg::TERM_W;
  localparam int unsigned OUT_W  = cac_pkg::OUT_W;

  localparam logic [1:0] PART_LO_LO = 2'd0;
  localparam logic [1:0] PART_CROSS = 2'd1;
  localparam logic [1:0] PART_HI_HI = 2'd2;
  localparam logic [1:0] AXIS_LAST  = 2'd2;

  cac_pkg::cac_ast_e st_q, st_d;

  logic [COORD_BITS-1:0]      diff [3];
  logic [EXT_W-1:0]           ext  [3];
  logic [PAIR_W-1:0]          pxy_q;
  logic [PAIR_W-1:0]          sq_q [3];
  logic [VOL_W-1:0]           vol;
  logic [DIAG_W-1:0]          diag;

  logic [1:0]                 axis_q, part_q, prod_part_q;
  logic                       prod_v_q;
  logic [2*HALF_W-1:0]        prod_q, product;
  logic [cac_pkg::SUM_W-1:0]  sq_src;
  logic [HALF_W-1:0]          mul_a, mul_b;
  logic [SQ_W-1:0]            acc_q, acc_n, addend;

  logic [DVD_W-1:0]           quo1_q;
  logic [TERM_W-1:0]          term_q;
  logic                       over;

  logic [cac_pkg::SUM_W-1:0]  mean_sum;
  logic                       is_mean;
  logic                       zero_count;

  logic                       div_start, div_done;
  logic [DVD_W-1:0]           div_dvd, div_quo;
  logic [cac_pkg::COUNT_W-1:0] div_dsr;

  logic [OUT_W-1:0]           res_q, res_d;

  // Box extents per axis, wrapping in the coordinate width
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = box_max_i[k*COORD_BITS +: COORD_BITS] - box_min_i[k*COORD_BITS +: COORD_BITS];
      ext[k]  = {1'b0, diff[k]} + EXT_W'(1);
    end
  end

  assign vol  = pxy_q * ext[2];
  assign diag = DIAG_W'(sq_q[0]) + DIAG_W'(sq_q[1]) + DIAG_W'(sq_q[2]);

  // Select mean axis
  assign is_mean = (sel_i == cac_pkg::SEL_MEAN_X) || (sel_i == cac_pkg::SEL_MEAN_Y) ||
                   (sel_i == cac_pkg::SEL_MEAN_Z);
  assign zero_count = (count_i == '0);

  always_comb begin
    unique case (sel_i)
      cac_pkg::SEL_MEAN_X: mean_sum = sum_x_i;
      cac_pkg::SEL_MEAN_Y: mean_sum = sum_y_i;
      default:             mean_sum = sum_z_i;
    endcase
  end

  // Squared coordinate sums: one 20x20 partial product per cycle
  always_comb begin
    unique case (axis_q)
      2'd0:    sq_src = sum_x_i;
      2'd1:    sq_src = sum_y_i;
      default: sq_src = sum_z_i;
    endcase
    unique case (part_q)
      PART_LO_LO: begin
        mul_a = sq_src[HALF_W-1:0];
        mul_b = sq_src[HALF_W-1:0];
      end
      PART_CROSS: begin
        mul_a = sq_src[2*HALF_W-1:HALF_W];
        mul_b = sq_src[HALF_W-1:0];
      end
      default: begin
        mul_a = sq_src[2*HALF_W-1:HALF_W];
        mul_b = sq_src[2*HALF_W-1:HALF_W];
      end
    endcase
    product = mul_a * mul_b;
  end

  // Place the registered partial product and accumulate
  always_comb begin
    unique case (prod_part_q)
      PART_LO_LO: addend = SQ_W'(prod_q);
      PART_CROSS: addend = SQ_W'(prod_q) << (HALF_W + 1);
      default:    addend = SQ_W'(prod_q) << (2 * HALF_W);
    endcase
    acc_n = acc_q + (prod_v_q ? addend : '0);
  end

  assign over = |quo1_q[DVD_W-1:TERM_W];

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      cac_pkg::A_IDLE: begin
        if (start_i) begin
          unique case (sel_i)
            cac_pkg::SEL_AREA:     st_d = cac_pkg::A_DONE;
            cac_pkg::SEL_VOLUME,
            cac_pkg::SEL_DIAGONAL: st_d = cac_pkg::A_GEO_PROD;
            cac_pkg::SEL_INERTIA:  st_d = zero_count ? cac_pkg::A_DONE : cac_pkg::A_SQ_MUL;
            cac_pkg::SEL_MEAN_X,
            cac_pkg::SEL_MEAN_Y,
            cac_pkg::SEL_MEAN_Z:   st_d = zero_count ? cac_pkg::A_DONE : cac_pkg::A_DIV_MEAN;
            default:               st_d = cac_pkg::A_DONE;
          endcase
        end
      end
      cac_pkg::A_GEO_PROD: st_d = cac_pkg::A_GEO_SUM;
      cac_pkg::A_GEO_SUM:  st_d = cac_pkg::A_DONE;
      cac_pkg::A_SQ_MUL: begin
        if (axis_q == AXIS_LAST && part_q == PART_HI_HI) begin
          st_d = cac_pkg::A_SQ_LAST;
        end
      end
      cac_pkg::A_SQ_LAST:   st_d = cac_pkg::A_DIV_SQ;
      cac_pkg::A_DIV_SQ:    if (div_done) st_d = cac_pkg::A_DIV_SIXTH;
      cac_pkg::A_DIV_SIXTH: if (div_done) st_d = cac_pkg::A_INERTIA;
      cac_pkg::A_INERTIA:   st_d = cac_pkg::A_DONE;
      cac_pkg::A_DIV_MEAN:  if (div_done) st_d = cac_pkg::A_DONE;
      cac_pkg::A_DONE:      st_d = cac_pkg::A_IDLE;
      default:              st_d = cac_pkg::A_IDLE;
    endcase
  end

  // Outputs: divider requests and result strobe
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = count_i;
    unique case (st_q)
      cac_pkg::A_IDLE: begin
        if (start_i && is_mean && !zero_count) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(mean_sum) << FRACTION_BITS;
        end
      end
      cac_pkg::A_SQ_LAST: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(acc_n) << FRACTION_BITS;
      end
      cac_pkg::A_DIV_SQ: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(count_i) << FRACTION_BITS;
          div_dsr   = cac_pkg::INERTIA_DIVISOR;
        end
      end
      default: ;
    endcase
  end

  assign done_o  = (st_q == cac_pkg::A_DONE);
  assign value_o = res_q;

  // Result value
  always_comb begin
    res_d = res_q;
    unique case (st_q)
      cac_pkg::A_IDLE: begin
        if (start_i) begin
          res_d = (sel_i == cac_pkg::SEL_AREA) ? (OUT_W'(count_i) << FRACTION_BITS) : '0;
        end
      end
      cac_pkg::A_GEO_SUM: begin
        res_d = (sel_i == cac_pkg::SEL_VOLUME) ? (OUT_W'(vol) << FRACTION_BITS)
                                               : (OUT_W'(diag) << FRACTION_BITS);
      end
      cac_pkg::A_INERTIA: begin
        res_d = (over || quo1_q[TERM_W-1:0] > term_q) ? '0
                : OUT_W'(term_q - quo1_q[TERM_W-1:0]);
      end
      cac_pkg::A_DIV_MEAN: begin
        if (div_done) begin
          res_d = OUT_W'(div_quo);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cac_pkg::A_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    unique case (st_q)
      cac_pkg::A_IDLE: begin
        acc_q    <= '0;
        axis_q   <= '0;
        part_q   <= PART_LO_LO;
        prod_v_q <= 1'b0;
      end
      cac_pkg::A_GEO_PROD: begin
        pxy_q <= ext[0] * ext[1];
        for (int k = 0; k < 3; k++) begin
          sq_q[k] <= ext[k] * ext[k];
        end
      end
      cac_pkg::A_SQ_MUL: begin
        prod_q      <= product;
        prod_part_q <= part_q;
        prod_v_q    <= 1'b1;
        acc_q       <= acc_n;
        if (part_q == PART_HI_HI) begin
          part_q <= PART_LO_LO;
          axis_q <= axis_q + 2'd1;
        end else begin
          part_q <= part_q + 2'd1;
        end
      end
      cac_pkg::A_SQ_LAST: begin
        acc_q    <= acc_n;
        prod_v_q <= 1'b0;
      end
      cac_pkg::A_DIV_SQ: begin
        if (div_done) begin
          quo1_q <= div_quo;
        end
      end
      cac_pkg::A_DIV_SIXTH: begin
        if (div_done) begin
          term_q <= (TERM_W'(r2_i) << FRACTION_BITS) + TERM_W'(div_quo);
        end
      end
      default: ;
    endcase
  end

  cac_div #(
    .DVD_W (DVD_W),
    .DSR_W (cac_pkg::COUNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule

// ===== rtl/cac_front.sv =====
// ----------------------------------------------------------------------------
// cac_front
// Command front: accepts commands, reduces indexes, classifies, and queues.
// ----------------------------------------------------------------------------
module cac_front #(
  parameter int unsigned ENTRY_COUNT = 1024,
  parameter int unsigned COORD_BITS  = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [cac_pkg::OP_W-1:0]            opcode_i,
  input  logic [cac_pkg::ENTRY_W-1:0]         target_entry_i,
  input  logic [cac_pkg::ENTRY_W-1:0]         source_entry_i,
  input  logic [cac_pkg::VOXEL_W-1:0]         voxel_x_i,
  input  logic [cac_pkg::VOXEL_W-1:0]         voxel_y_i,
  input  logic [cac_pkg::VOXEL_W-1:0]         voxel_z_i,
  output logic                                cmd_valid_o,
  output cac_pkg::cac_ctl_t                   cmd_ctl_o,
  output logic [$clog2(ENTRY_COUNT)-1:0]      cmd_target_o,
  output logic [$clog2(ENTRY_COUNT)-1:0]      cmd_source_o,
  output logic [3*COORD_BITS-1:0]             cmd_voxel_o,
  output logic [2*COORD_BITS+1:0]             cmd_r2_o,
  input  logic                                cmd_pop_i
);

  localparam int unsigned IDX_W   = $clog2(ENTRY_COUNT);
  localparam int unsigned BOX_W   = 3 * COORD_BITS;
  localparam int unsigned R2V_W   = 2 * COORD_BITS + 2;
  localparam int unsigned PAY_W   = R2V_W + BOX_W + 2 * IDX_W;
  localparam int unsigned ENTRY_W = cac_pkg::ENTRY_W;

  logic [1:0]                tail_fill_q, fill_d;
  logic                      wr_q, rd_q;
  logic                      push;
  logic [PAY_W-1:0]          pay_q [2];
  cac_pkg::cac_ctl_t         ctl_q [2];
  logic [PAY_W-1:0]          pay_d;
  cac_pkg::cac_ctl_t         ctl_d;
  logic [PAY_W-1:0]          pay_out;
  logic [ENTRY_W-1:0]        tgt_rem, src_rem;
  logic [COORD_BITS-1:0]     vx, vy, vz;
  logic [R2V_W-1:0]          r2;

  assign busy = (tail_fill_q == 2'd2);
  assign push = start && !busy;

  // Reduce entry indexes modulo the table depth
  always_comb begin
    tgt_rem = target_entry_i;
    src_rem = source_entry_i;
    for (int s = ENTRY_W - 1; s >= 0; s--) begin
      if (32'(tgt_rem) >= (ENTRY_COUNT << s)) begin
        tgt_rem = tgt_rem - ENTRY_W'(ENTRY_COUNT << s);
      end
      if (32'(src_rem) >= (ENTRY_COUNT << s)) begin
        src_rem = src_rem - ENTRY_W'(ENTRY_COUNT << s);
      end
    end
  end

  // Classify the command and precompute the squared voxel radius
  assign vx = voxel_x_i[COORD_BITS-1:0];
  assign vy = voxel_y_i[COORD_BITS-1:0];
  assign vz = voxel_z_i[COORD_BITS-1:0];
  assign r2 = R2V_W'(vx) * R2V_W'(vx) + R2V_W'(vy) * R2V_W'(vy) + R2V_W'(vz) * R2V_W'(vz);

  always_comb begin
    ctl_d.op           = cac_pkg::cac_op_e'(opcode_i);
    ctl_d.reads_target = (ctl_d.op == cac_pkg::OP_ADD) || (ctl_d.op == cac_pkg::OP_MERGE);
    ctl_d.reads_source = (ctl_d.op == cac_pkg::OP_MERGE) || (ctl_d.op == cac_pkg::OP_CLONE);
    pay_d = {r2, vz, vy, vx, IDX_W'(src_rem), IDX_W'(tgt_rem)};
  end

  // Two-entry queue toward the back
  assign fill_d = tail_fill_q + 2'(push) - 2'(cmd_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_fill_q <= '0;
      wr_q        <= 1'b0;
      rd_q        <= 1'b0;
    end else begin
      tail_fill_q <= fill_d;
      wr_q        <= wr_q ^ push;
      rd_q        <= rd_q ^ cmd_pop_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      pay_q[wr_q] <= pay_d;
      ctl_q[wr_q] <= ctl_d;
    end
  end

  assign pay_out      = pay_q[rd_q];
  assign cmd_valid_o  = (tail_fill_q != 2'd0);
  assign cmd_ctl_o    = ctl_q[rd_q];
  assign cmd_target_o = pay_out[IDX_W-1:0];
  assign cmd_source_o = pay_out[2*IDX_W-1:IDX_W];
  assign cmd_voxel_o  = pay_out[2*IDX_W+BOX_W-1:2*IDX_W];
  assign cmd_r2_o     = pay_out[PAY_W-1:2*IDX_W+BOX_W];

endmodule

// ===== rtl/cac_back.sv =====
// ----------------------------------------------------------------------------
// cac_back
// Command back: record read-modify-write in the table, then attribute report.
// ----------------------------------------------------------------------------
module cac_back #(
  parameter int unsigned ENTRY_COUNT   = 1024,
  parameter int unsigned COORD_BITS    = 10,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  cac_pkg::cac_ctl_t                cmd_ctl_i,
  input  logic [$clog2(ENTRY_COUNT)-1:0]   cmd_target_i,
  input  logic [$clog2(ENTRY_COUNT)-1:0]   cmd_source_i,
  input  logic [3*COORD_BITS-1:0]          cmd_voxel_i,
  input  logic [2*COORD_BITS+1:0]          cmd_r2_i,
  output logic                             cmd_pop_o,
  input  logic [cac_pkg::SEL_W-1:0]        sel_i,
  output logic                             result_valid_o,
  output logic [cac_pkg::OUT_W-1:0]        result_value_o
);

  localparam int unsigned IDX_W   = $clog2(ENTRY_COUNT);
  localparam int unsigned BOX_W   = 3 * COORD_BITS;
  localparam int unsigned R2V_W   = 2 * COORD_BITS + 2;
  localparam int unsigned COUNT_W = cac_pkg::COUNT_W;
  localparam int unsigned SUM_W   = cac_pkg::SUM_W;
  localparam int unsigned R2_W    = cac_pkg::R2_W;
  localparam int unsigned O_MIN   = COUNT_W;
  localparam int unsigned O_MAX   = O_MIN + BOX_W;
  localparam int unsigned O_SX    = O_MAX + BOX_W;
  localparam int unsigned O_SY    = O_SX + SUM_W;
  localparam int unsigned O_SZ    = O_SY + SUM_W;
  localparam int unsigned O_R2    = O_SZ + SUM_W;
  localparam int unsigned REC_W   = O_R2 + R2_W;

  cac_pkg::cac_bst_e st_q, st_d;
  cac_pkg::cac_ctl_t ctl_q;
  logic [IDX_W-1:0]  tgt_idx_q, src_idx_q, raddr;
  logic [BOX_W-1:0]  vox_q;
  logic [R2V_W-1:0]  r2_q;
  logic [REC_W-1:0]  tgt_q, src_q, rec_q, rec_d, rdata, vox_rec, merged, opnd;
  logic              attr_start, attr_done;
  logic [BOX_W-1:0]  mn, mx;

  // Voxel as a one-voxel record
  assign vox_rec = {R2_W'(r2_q),
                    SUM_W'(vox_q[3*COORD_BITS-1:2*COORD_BITS]),
                    SUM_W'(vox_q[2*COORD_BITS-1:COORD_BITS]),
                    SUM_W'(vox_q[COORD_BITS-1:0]),
                    vox_q, vox_q, COUNT_W'(1)};

  assign opnd = (ctl_q.op == cac_pkg::OP_MERGE) ? src_q : vox_rec;

  // Combine the target with the operand record, wrapping sums
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mn[k*COORD_BITS +: COORD_BITS] =
        (tgt_q[O_MIN + k*COORD_BITS +: COORD_BITS] < opnd[O_MIN + k*COORD_BITS +: COORD_BITS])
        ? tgt_q[O_MIN + k*COORD_BITS +: COORD_BITS] : opnd[O_MIN + k*COORD_BITS +: COORD_BITS];
      mx[k*COORD_BITS +: COORD_BITS] =
        (tgt_q[O_MAX + k*COORD_BITS +: COORD_BITS] > opnd[O_MAX + k*COORD_BITS +: COORD_BITS])
        ? tgt_q[O_MAX + k*COORD_BITS +: COORD_BITS] : opnd[O_MAX + k*COORD_BITS +: COORD_BITS];
    end
    merged = {tgt_q[O_R2 +: R2_W] + opnd[O_R2 +: R2_W],
              tgt_q[O_SZ +: SUM_W] + opnd[O_SZ +: SUM_W],
              tgt_q[O_SY +: SUM_W] + opnd[O_SY +: SUM_W],
              tgt_q[O_SX +: SUM_W] + opnd[O_SX +: SUM_W],
              mx, mn,
              tgt_q[COUNT_W-1:0] + opnd[COUNT_W-1:0]};
    unique case (ctl_q.op)
      cac_pkg::OP_NEW:   rec_d = vox_rec;
      cac_pkg::OP_CLONE: rec_d = src_q;
      default:           rec_d = merged;
    endcase
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      cac_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_ctl_i.reads_target) begin
            st_d = cac_pkg::B_READ_TGT;
          end else if (cmd_ctl_i.reads_source) begin
            st_d = cac_pkg::B_READ_SRC;
          end else begin
            st_d = cac_pkg::B_UPDATE;
          end
        end
      end
      cac_pkg::B_READ_TGT: st_d = ctl_q.reads_source ? cac_pkg::B_READ_SRC : cac_pkg::B_UPDATE;
      cac_pkg::B_READ_SRC: st_d = cac_pkg::B_UPDATE;
      cac_pkg::B_UPDATE:   st_d = cac_pkg::B_ATTR;
      cac_pkg::B_ATTR:     st_d = cac_pkg::B_WAIT;
      cac_pkg::B_WAIT:     if (attr_done) st_d = cac_pkg::B_IDLE;
      default:             st_d = cac_pkg::B_IDLE;
    endcase
  end

  // Outputs: queue pop, read address, attribute start
  always_comb begin
    cmd_pop_o  = 1'b0;
    attr_start = 1'b0;
    raddr      = src_idx_q;
    unique case (st_q)
      cac_pkg::B_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        raddr     = cmd_ctl_i.reads_target ? cmd_target_i : cmd_source_i;
      end
      cac_pkg::B_ATTR: attr_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cac_pkg::B_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Hold the command and the records read
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      cac_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          ctl_q     <= cmd_ctl_i;
          tgt_idx_q <= cmd_target_i;
          src_idx_q <= cmd_source_i;
          vox_q     <= cmd_voxel_i;
          r2_q      <= cmd_r2_i;
        end
      end
      cac_pkg::B_READ_TGT: tgt_q <= rdata;
      cac_pkg::B_READ_SRC: src_q <= rdata;
      cac_pkg::B_UPDATE:   rec_q <= rec_d;
      default: ;
    endcase
  end

  cac_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRY_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (st_q == cac_pkg::B_UPDATE),
    .waddr_i (tgt_idx_q),
    .wdata_i (rec_d),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cac_attr #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_attr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (attr_start),
    .sel_i     (sel_i),
    .count_i   (rec_q[COUNT_W-1:0]),
    .box_min_i (rec_q[O_MIN +: BOX_W]),
    .box_max_i (rec_q[O_MAX +: BOX_W]),
    .sum_x_i   (rec_q[O_SX +: SUM_W]),
    .sum_y_i   (rec_q[O_SY +: SUM_W]),
    .sum_z_i   (rec_q[O_SZ +: SUM_W]),
    .r2_i      (rec_q[O_R2 +: R2_W]),
    .done_o    (attr_done),
    .value_o   (result_value_o)
  );

  assign result_valid_o = attr_done;

endmodule
